/* rtl/pwmc_pkg.sv */
`default_nettype none

package pwmc_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int MISSED_WIDTH_DEF  = 8;

  localparam int CFG_INDEX_WIDTH = 1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_AUTO_RELOAD  = 1'b0,
    CFG_MISSED_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    FUNC_EDGE   = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_t;

  localparam int MISSED_LIMIT_RST = 3;

endpackage

`default_nettype wire

/* rtl/pwmc_meas.sv */
`default_nettype none

module pwmc_meas #(
  parameter int COUNTER_WIDTH = pwmc_pkg::COUNTER_WIDTH_DEF,
  parameter int MISSED_WIDTH  = pwmc_pkg::MISSED_WIDTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      step,
  input  wire                      func,
  input  wire  [COUNTER_WIDTH-1:0] counter_value,
  input  wire                      pin_level,
  input  wire  [COUNTER_WIDTH-1:0] auto_reload,
  input  wire  [MISSED_WIDTH-1:0]  missed_limit,
  output logic [COUNTER_WIDTH:0]   res_period,
  output logic [COUNTER_WIDTH-1:0] res_duty,
  output logic                     res_timeout
);
  import pwmc_pkg::*;

  logic [COUNTER_WIDTH-1:0] last_count, last_count_next;
  logic [COUNTER_WIDTH-1:0] duty_store, duty_store_next;
  logic [COUNTER_WIDTH:0]   period_store, period_store_next;
  logic [MISSED_WIDTH-1:0]  missed_count, missed_count_next;
  logic                     capture_started, capture_started_next;

  logic [COUNTER_WIDTH-1:0] diff;
  logic [COUNTER_WIDTH:0]   reload_p1;
  logic [COUNTER_WIDTH:0]   wrap_sum;
  logic [COUNTER_WIDTH-1:0] elapsed;
  logic [COUNTER_WIDTH:0]   period_sum;
  logic [MISSED_WIDTH-1:0]  missed_inc;
  logic                     fired;

  // Elapsed ticks since the previous edge, wrapped at auto_reload + 1.
  always_comb begin
    diff      = counter_value - last_count;
    reload_p1 = {1'b0, auto_reload} + {{COUNTER_WIDTH{1'b0}}, 1'b1};
    wrap_sum  = {1'b0, diff} + reload_p1;
    if (counter_value < last_count) begin
      elapsed = wrap_sum[COUNTER_WIDTH-1:0];
    end else begin
      elapsed = diff;
    end
    period_sum = {1'b0, elapsed} + {1'b0, duty_store};
    missed_inc = missed_count + {{(MISSED_WIDTH-1){1'b0}}, 1'b1};
  end

  always_comb begin
    last_count_next      = last_count;
    duty_store_next      = duty_store;
    period_store_next    = period_store;
    missed_count_next    = missed_count;
    capture_started_next = capture_started;
    fired                = 1'b0;
    case (func_t'(func))
      FUNC_EDGE: begin
        missed_count_next = '0;
        last_count_next   = counter_value;
        if (last_count != '0) begin
          capture_started_next = 1'b1;
          if (pin_level) begin
            if (duty_store != '0) begin
              period_store_next = period_sum;
            end
          end else begin
            duty_store_next = elapsed;
          end
        end
      end
      FUNC_UPDATE: begin
        if (capture_started && (missed_count != missed_limit)) begin
          missed_count_next = missed_inc;
          if (missed_inc == missed_limit) begin
            period_store_next = '0;
            duty_store_next   = '0;
            fired             = 1'b1;
          end
        end
      end
      default: begin
        fired = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count      <= '0;
      duty_store      <= '0;
      period_store    <= '0;
      missed_count    <= '0;
      capture_started <= 1'b0;
    end else if (step) begin
      last_count      <= last_count_next;
      duty_store      <= duty_store_next;
      period_store    <= period_store_next;
      missed_count    <= missed_count_next;
      capture_started <= capture_started_next;
    end
  end

  assign res_period  = period_store_next;
  assign res_duty    = duty_store_next;
  assign res_timeout = fired;

endmodule

`default_nettype wire

/* rtl/pwm_edge_capture_timeout.sv */
// Each item passes the input register, then the output register that
// offers its result. Throughput: one item per cycle while the output
// accepts; each item sees the measurement state left by the one before.
// Reset: synchronous and active high; it empties both pipeline registers,
// clears all measurements and loads the register reset values.
`default_nettype none

module pwm_edge_capture_timeout #(
  parameter int COUNTER_WIDTH = pwmc_pkg::COUNTER_WIDTH_DEF,
  parameter int MISSED_WIDTH  = pwmc_pkg::MISSED_WIDTH_DEF,
  localparam int CfgWidth = (COUNTER_WIDTH > MISSED_WIDTH) ? COUNTER_WIDTH : MISSED_WIDTH
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [pwmc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire  [CfgWidth-1:0]                    cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire                                    func,
  input  wire  [COUNTER_WIDTH-1:0]               counter_value,
  input  wire                                    pin_level,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic [COUNTER_WIDTH:0]                 period_ticks,
  output logic [COUNTER_WIDTH-1:0]               duty_ticks,
  output logic                                   timeout
);
  import pwmc_pkg::*;

  logic [COUNTER_WIDTH-1:0] auto_reload;
  logic [MISSED_WIDTH-1:0]  missed_limit;

  logic                     s1_valid;
  logic                     s1_func;
  logic [COUNTER_WIDTH-1:0] s1_count;
  logic                     s1_level;
  logic                     s1_go;

  logic [COUNTER_WIDTH:0]   res_period;
  logic [COUNTER_WIDTH-1:0] res_duty;
  logic                     res_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_reload  <= '1;
      missed_limit <= MISSED_WIDTH'(MISSED_LIMIT_RST);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_AUTO_RELOAD:  auto_reload  <= cfg_data[COUNTER_WIDTH-1:0];
        CFG_MISSED_LIMIT: missed_limit <= cfg_data[MISSED_WIDTH-1:0];
        default: begin
          auto_reload <= auto_reload;
        end
      endcase
    end
  end

  assign s1_go    = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func  <= func;
      s1_count <= counter_value;
      s1_level <= pin_level;
    end
  end

  pwmc_meas #(
    .COUNTER_WIDTH(COUNTER_WIDTH),
    .MISSED_WIDTH (MISSED_WIDTH)
  ) u_meas (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_valid && s1_go),
    .func         (s1_func),
    .counter_value(s1_count),
    .pin_level    (s1_level),
    .auto_reload  (auto_reload),
    .missed_limit (missed_limit),
    .res_period   (res_period),
    .res_duty     (res_duty),
    .res_timeout  (res_timeout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      period_ticks <= res_period;
      duty_ticks   <= res_duty;
      timeout      <= res_timeout;
    end
  end

endmodule

`default_nettype wire

/* rtl/pwmc_checker.sv */
`default_nettype none

module pwmc_checker #(
  parameter int COUNTER_WIDTH = pwmc_pkg::COUNTER_WIDTH_DEF
) (
  input wire                     clk,
  input wire                     rst,
  input wire                     in_valid,
  input wire                     in_ready,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire [COUNTER_WIDTH:0]   period_ticks,
  input wire [COUNTER_WIDTH-1:0] duty_ticks,
  input wire                     timeout
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(period_ticks)
      && $stable(duty_ticks) && $stable(timeout))
    else $error("result changed while stalled");

  // A timeout always reports cleared measurements.
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout |-> period_ticks == '0 && duty_ticks == '0)
    else $error("timeout with nonzero measurement");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  // An offered item stays offered until it is accepted.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before acceptance");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind pwm_edge_capture_timeout pwmc_checker #(
  .COUNTER_WIDTH(COUNTER_WIDTH)
) u_pwmc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .period_ticks(period_ticks),
  .duty_ticks  (duty_ticks),
  .timeout     (timeout)
);

`default_nettype wire

/* verif/pwm_edge_capture_timeout_tb.sv */
`timescale 1ns / 100ps

module pwm_edge_capture_timeout_tb;
  import pwmc_pkg::*;

  localparam int CW = COUNTER_WIDTH_DEF;
  localparam int MW = MISSED_WIDTH_DEF;
  localparam int CFGW = (CW > MW) ? CW : MW;
  localparam int N_DIRECTED = 17;
  localparam int N_PHASES = 6;

  typedef struct packed {
    func_t         kind;
    logic [CW-1:0] count;
    logic          level;
  } pwm_event_t;

  typedef struct packed {
    logic [CW:0]   period;
    logic [CW-1:0] duty;
    logic          timeout;
  } meas_t;

  typedef struct packed {
    func_t         kind;
    logic [CW-1:0] count;
    logic          level;
    logic          fixed;
    logic [CW:0]   period;
    logic [CW-1:0] duty;
    logic          timeout;
  } dir_row_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  cfg_index_t      cfg_index = CFG_AUTO_RELOAD;
  logic [CFGW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  func_t           func = FUNC_EDGE;
  logic [CW-1:0]   counter_value = '0;
  logic            pin_level = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [CW:0]     period_ticks;
  logic [CW-1:0]   duty_ticks;
  logic            timeout;

  // Measurement state and register copies for the predictor.
  logic [CW-1:0] reload_val = 16'd65535;
  logic [MW-1:0] miss_limit = 8'd3;
  logic [CW-1:0] meas_last = '0;
  logic [CW-1:0] meas_duty = '0;
  logic [CW:0]   meas_period = '0;
  logic [MW-1:0] miss_cnt = '0;
  logic          capture_on = 1'b0;

  meas_t expected_meas[$];
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_asked = 0;
  int    hold_done = 0;
  int    hold_left = 0;
  int    items_sent = 0;
  int    results_seen = 0;
  int    timeouts_seen = 0;
  int    fail_count = 0;
  int    settings_used = 1;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{FUNC_UPDATE, 16'd0,     1'b0, 1'b1, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd100,   1'b1, 1'b1, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd400,   1'b0, 1'b1, 17'd0,      16'd300,   1'b0},
    '{FUNC_EDGE,   16'd1100,  1'b1, 1'b1, 17'd1000,   16'd300,   1'b0},
    '{FUNC_UPDATE, 16'd0,     1'b0, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_UPDATE, 16'hFFFF,  1'b1, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_UPDATE, 16'd0,     1'b0, 1'b1, 17'd0,      16'd0,     1'b1},
    '{FUNC_UPDATE, 16'd0,     1'b0, 1'b1, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd1500,  1'b1, 1'b1, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'hFFFF,  1'b0, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd0,     1'b1, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd50,    1'b0, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd40,    1'b0, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd2,     1'b1, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd1,     1'b0, 1'b0, 17'd0,      16'd0,     1'b0},
    '{FUNC_EDGE,   16'd0,     1'b1, 1'b1, 17'd131070, 16'd65535, 1'b0},
    '{FUNC_UPDATE, 16'hFFFF,  1'b1, 1'b0, 17'd0,      16'd0,     1'b0}
  };

  pwm_edge_capture_timeout u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .counter_value(counter_value),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .period_ticks (period_ticks),
    .duty_ticks   (duty_ticks),
    .timeout      (timeout)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic meas_t capture_step(input pwm_event_t ev);
    logic [CW-1:0] span;
    meas_t         res;
    res.timeout = 1'b0;
    if (ev.kind == FUNC_UPDATE) begin
      if (capture_on && miss_cnt != miss_limit) begin
        miss_cnt = miss_cnt + 1'b1;
        if (miss_cnt == miss_limit) begin
          meas_period = '0;
          meas_duty = '0;
          res.timeout = 1'b1;
        end
      end
    end else begin
      miss_cnt = '0;
      // A stored sample of zero means there is no previous edge to measure from.
      if (meas_last != '0) begin
        span = ev.count - meas_last;
        if (ev.count < meas_last) begin
          span = span + reload_val + 1'b1;
        end
        capture_on = 1'b1;
        if (ev.level) begin
          if (meas_duty != '0) begin
            meas_period = span + meas_duty;
          end
        end else begin
          meas_duty = span;
        end
      end
      meas_last = ev.count;
    end
    res.period = meas_period;
    res.duty = meas_duty;
    return res;
  endfunction

  task automatic send_event(input pwm_event_t ev, input logic fixed, input meas_t want);
    meas_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= ev.kind;
    counter_value <= ev.count;
    pin_level <= ev.level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = capture_step(ev);
    expected_meas.push_back(fixed ? want : predicted);
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_meas.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [CW-1:0] reload, input logic [MW-1:0] limit);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AUTO_RELOAD;
    cfg_data <= CFGW'(reload);
    @(posedge clk);
    reload_val = reload;
    cfg_index <= CFG_MISSED_LIMIT;
    cfg_data <= CFGW'(limit);
    @(posedge clk);
    miss_limit = limit;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_updates(input int n);
    pwm_event_t ev;
    for (int i = 0; i < n; i++) begin
      ev.kind = FUNC_UPDATE;
      ev.count = CW'($urandom_range(65535));
      ev.level = 1'($urandom_range(1));
      send_event(ev, 1'b0, '0);
    end
  endtask

  // Mostly alternating edges on a counter that wraps at the reload value,
  // with bursts of updates to reach the timeout and some arbitrary edges.
  task automatic run_random(input int n_items);
    int         sent;
    int         pick;
    int         len;
    int         step;
    int         cur_cnt;
    logic       cur_lvl;
    pwm_event_t ev;
    sent = 0;
    cur_cnt = $urandom_range(int'(reload_val));
    cur_lvl = 1'($urandom_range(1));
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        len = $urandom_range((miss_limit < 6) ? int'(miss_limit) + 1 : 6, 1);
        send_updates(len);
        sent += len;
      end else if (pick < 22) begin
        ev.kind = FUNC_EDGE;
        ev.count = ($urandom_range(7) == 0) ? '0 : CW'($urandom_range(65535));
        ev.level = 1'($urandom_range(1));
        cur_cnt = ev.count;
        cur_lvl = ev.level;
        send_event(ev, 1'b0, '0);
        sent++;
      end else begin
        if ($urandom_range(3) == 0) begin
          step = $urandom_range(int'(reload_val), 1);
        end else begin
          step = $urandom_range((reload_val < 300) ? int'(reload_val) : 300, 1);
        end
        cur_cnt = (cur_cnt + step) % (int'(reload_val) + 1);
        cur_lvl = ~cur_lvl;
        ev.kind = FUNC_EDGE;
        ev.count = CW'(cur_cnt);
        ev.level = cur_lvl;
        send_event(ev, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      out_ready <= 1'b0;
      hold_left <= 80;
      hold_done <= hold_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    meas_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (timeout) begin
        timeouts_seen++;
      end
      if (expected_meas.size() == 0) begin
        $error("result arrived with nothing expected: period %0d duty %0d timeout %0d",
               period_ticks, duty_ticks, timeout);
        fail_count++;
      end else begin
        want = expected_meas.pop_front();
        if (period_ticks !== want.period) begin
          $error("period_ticks: expected %0d, actual %0d", want.period, period_ticks);
          fail_count++;
        end
        if (duty_ticks !== want.duty) begin
          $error("duty_ticks: expected %0d, actual %0d", want.duty, duty_ticks);
          fail_count++;
        end
        if (timeout !== want.timeout) begin
          $error("timeout: expected %0d, actual %0d", want.timeout, timeout);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results still expected.", expected_meas.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    pwm_event_t      ev;
    meas_t           want;
    logic [CW-1:0]   ph_reload [N_PHASES];
    logic [MW-1:0]   ph_limit [N_PHASES];
    ph_reload = '{16'd65535, 16'd1, 16'd999, 16'd40000, 16'd0, 16'd7};
    ph_limit = '{8'd3, 8'd1, 8'd255, 8'd8, 8'd0, 8'd2};
    ph_reload[4] = CW'($urandom_range(65535, 1));
    ph_limit[4] = MW'($urandom_range(8, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 32;
    recv_idle_pct = 79;
    foreach (dir_rows[i]) begin
      ev.kind = dir_rows[i].kind;
      ev.count = dir_rows[i].count;
      ev.level = dir_rows[i].level;
      want.period = dir_rows[i].period;
      want.duty = dir_rows[i].duty;
      want.timeout = dir_rows[i].timeout;
      send_event(ev, dir_rows[i].fixed, want);
    end
    drain();

    // Leave the miss count above a lowered limit so that it has to wrap
    // around before the timeout fires.
    configure(16'd65535, 8'd255);
    ev.kind = FUNC_EDGE;
    ev.count = 16'd10;
    ev.level = 1'b1;
    send_event(ev, 1'b0, '0);
    ev.count = 16'd20;
    ev.level = 1'b0;
    send_event(ev, 1'b0, '0);
    send_updates(5);
    drain();
    configure(16'd65535, 8'd2);
    send_updates(255);
    ev.count = 16'd30;
    ev.level = 1'b1;
    send_event(ev, 1'b0, '0);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 79;
      end else if (p < 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure(ph_reload[p], ph_limit[p]);
      if (p == 4) begin
        hold_asked++;
      end
      run_random(130);
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d events under %0d register settings: %0d results, %0d timeouts.",
             items_sent, settings_used, results_seen, timeouts_seen);
    $display("Included wrapping counters, zero samples, limit wrap-around and a long output stall.");
    if (fail_count == 0 && expected_meas.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
